FILE: hdl/sliding_window_average_top_defines.svh
// ----------------------------------------------------------------------------
// Sliding window average assertion macros
// Concurrent property wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_AVERAGE_TOP_DEFINES_SVH
`define SLIDING_WINDOW_AVERAGE_TOP_DEFINES_SVH

`ifndef SYNTH
`define SWA_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sliding window average: same-cycle check failed");
`define SWA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sliding window average: next-cycle check failed");
`else
`define SWA_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define SWA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: hdl/swa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window average package
// Widths, reset length, saturation limits and controller states shared by the block.
// ----------------------------------------------------------------------------
package swa_pkg;

    localparam int WINDOW_MAX_DEF = 256;
    localparam int SAMPLE_W       = 16;
    localparam int SUM_W          = 24;
    localparam int LEN_W          = 9;

    localparam logic [LEN_W-1:0]    LEN_RESET = 9'd16;
    localparam logic [SAMPLE_W-1:0] AVG_MAX   = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] AVG_MIN   = 16'h8000;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PTR,
        ST_READ,
        ST_UPDATE,
        ST_DIV
    } swa_state_t;

endpackage

FILE: hdl/sliding_window_average_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window average top level
// Boxcar moving average of signed 16-bit samples over a programmable window.
//
// Samples enter on the s_ stream, averages leave on the m_ stream, one per
// sample. cfg_wen/cfg_wdata set the window length (1..WINDOW_MAX, zero acts
// as one); write it only while the block is idle.
// After aresetn the sample store is swept to zero, one entry per cycle, across
// all WINDOW_MAX entries (256 by default); s_tready stays low meanwhile.
// The block takes one sample at a time. A sample whose pointer step stays
// inside the window passes from transfer to m_tvalid through one store
// read, one sum update that starts the shared restoring divider, 24 divide
// steps and the output register load. s_tready returns with m_tvalid, so a
// new sample is taken only once the previous result has been loaded.
// When a shortened window leaves the pointer beyond its end, the wrap goes
// through the same divider first, before the store read.
// The result sits in an output register; a stalled receiver holds it there
// and the next sample is still taken, but its result waits for that register.
// ----------------------------------------------------------------------------
`include "sliding_window_average_top_defines.svh"

module sliding_window_average_top
    import swa_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wen,
    input  logic [LEN_W-1:0] cfg_wdata,   // [8:0] window_length
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [15:0]      s_tdata,     // [15:0] sample
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata      // [15:0] average
);

    localparam int PTR_W = $clog2(WINDOW_MAX);
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);

    swa_state_t           state_reg, state_next;
    logic [LEN_W-1:0]     wl_reg;
    logic [PTR_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [PTR_W-1:0]     wp_reg, wp_next;
    logic [PTR_W-1:0]     p_reg, p_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic                 neg_reg, neg_next;
    logic [SAMPLE_W-1:0]  sample_reg, sample_next;
    logic [SAMPLE_W-1:0]  rd_data_reg;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_W-1:0]  m_tdata_reg, m_tdata_next;

    logic [SAMPLE_W-1:0]  store_mem [WINDOW_MAX];
    logic                 mem_we;
    logic [PTR_W-1:0]     mem_waddr;
    logic [SAMPLE_W-1:0]  mem_wdata;

    logic [31:0]          wl_ext;
    logic [CNT_W-1:0]     eff_len;
    logic [CNT_W-1:0]     ptr_inc;
    logic [SUM_W-1:0]     sum_calc;
    logic [SUM_W-1:0]     sum_mag;
    logic signed [SUM_W:0] avg_wide;
    logic [SAMPLE_W-1:0]  avg_sat;
    logic                 result_load;

    logic                 div_start;
    logic [SUM_W-1:0]     div_dividend;
    logic                 div_done;
    logic [SUM_W-1:0]     div_quot;
    logic [CNT_W-1:0]     div_rem;

    swa_divider #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (eff_len),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    always_comb begin
        wl_ext = 32'(wl_reg);
        if (wl_ext == 32'd0) begin
            eff_len = CNT_W'(1);
        end else if (wl_ext > 32'(WINDOW_MAX)) begin
            eff_len = CNT_W'(WINDOW_MAX);
        end else begin
            eff_len = CNT_W'(wl_ext);
        end
        ptr_inc = CNT_W'(wp_reg) + CNT_W'(1);
    end

    always_comb begin
        sum_calc = sum_reg
                 - {{(SUM_W-SAMPLE_W){rd_data_reg[SAMPLE_W-1]}}, rd_data_reg}
                 + {{(SUM_W-SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg};
        sum_mag  = sum_calc[SUM_W-1] ? (~sum_calc + SUM_W'(1)) : sum_calc;
        avg_wide = neg_reg ? -signed'({1'b0, div_quot}) : signed'({1'b0, div_quot});
        if (avg_wide[SUM_W:SAMPLE_W-1] == '0 || avg_wide[SUM_W:SAMPLE_W-1] == '1) begin
            avg_sat = avg_wide[SAMPLE_W-1:0];
        end else begin
            avg_sat = avg_wide[SUM_W] ? AVG_MIN : AVG_MAX;
        end
    end

    assign result_load = div_done && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        wp_next       = wp_reg;
        p_next        = p_reg;
        sum_next      = sum_reg;
        neg_next      = neg_reg;
        sample_next   = sample_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        div_start     = 1'b0;
        div_dividend  = '0;
        mem_we        = 1'b0;
        mem_waddr     = p_reg;
        mem_wdata     = sample_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
                if (clr_cnt_reg == PTR_W'(WINDOW_MAX - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + PTR_W'(1);
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    sample_next = s_tdata;
                    if (ptr_inc < eff_len) begin
                        p_next     = ptr_inc[PTR_W-1:0];
                        state_next = ST_READ;
                    end else if (ptr_inc == eff_len) begin
                        p_next     = '0;
                        state_next = ST_READ;
                    end else begin
                        div_start    = 1'b1;
                        div_dividend = SUM_W'(ptr_inc);
                        state_next   = ST_PTR;
                    end
                end
            end
            ST_PTR: begin
                if (div_done) begin
                    p_next     = div_rem[PTR_W-1:0];
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                mem_we       = 1'b1;
                wp_next      = p_reg;
                sum_next     = sum_calc;
                neg_next     = sum_calc[SUM_W-1];
                div_start    = 1'b1;
                div_dividend = sum_mag;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                if (result_load) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = avg_sat;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            wp_reg       <= '0;
            sum_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            wl_reg       <= LEN_RESET;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            wp_reg       <= wp_next;
            sum_reg      <= sum_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wen) begin
                wl_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        p_reg       <= p_next;
        neg_reg     <= neg_next;
        sample_reg  <= sample_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == ST_READ) begin
            rd_data_reg <= store_mem[p_reg];
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `SWA_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `SWA_ASSERT_SAME(a_clear_blocks, aclk, aresetn, state_reg == ST_CLEAR, !s_tready && !m_tvalid)
    `SWA_ASSERT_NEXT(a_update_starts_div, aclk, aresetn, state_reg == ST_UPDATE, !div_done)
    `SWA_ASSERT_NEXT(a_result_loads, aclk, aresetn, state_reg == ST_DIV && result_load, m_tvalid && s_tready)

endmodule

FILE: hdl/swa_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window average divider
// Restoring unsigned divider, one quotient bit per cycle; results hold
// until the next start.
// ----------------------------------------------------------------------------
module swa_divider
    import swa_pkg::*;
#(
    parameter int DVD_W = SUM_W,
    parameter int DVS_W = 9
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient,
    output logic [DVS_W-1:0] remainder
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  dvd_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DVS_W:0]    trial;
    logic              fits;
    logic [DVS_W:0]    diff;

    always_comb begin
        trial = {rem_reg, dvd_reg[DVD_W-1]};
        fits  = (trial >= {1'b0, dvs_reg});
        diff  = trial - {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(DVD_W);
        end else if (busy_reg) begin
            step_reg <= step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

FILE: tb/sv/tb_sliding_window_average_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window average testbench
// Streams signed samples through the boxcar averager across a series of
// window lengths (reset value, 1, zero, 256, above 256 and random ones) and
// checks every average against an in-bench model of the ring store and
// running sum. Window changes land between drained phases so stale entries
// and saturated averages are exercised. Both stream sides idle in random
// bursts except in phases without idling and in the final phase.
// ----------------------------------------------------------------------------
module tb_sliding_window_average_top;
    import swa_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int ITEM_TARGET   = 1200;

    typedef enum int {
        SRC_FULL,
        SRC_POS_RAIL,
        SRC_NEG_RAIL,
        SRC_NEAR_ZERO
    } sample_src_t;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             cfg_wen   = 1'b0;
    logic [LEN_W-1:0] cfg_wdata = '0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [15:0]      s_tdata   = '0;   // [15:0] sample
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [15:0]      m_tdata;          // [15:0] average

    // Model state
    logic signed [15:0] window_samples [WINDOW_MAX_DEF];
    logic [7:0]         window_ptr     = '0;
    logic [23:0]        window_sum     = '0;
    logic [LEN_W-1:0]   window_len_cfg = LEN_RESET;

    logic [15:0] sample_backlog[$];
    logic [15:0] average_backlog[$];

    logic s_fire      = 1'b0;
    bit   idle_on     = 1'b1;
    int   gap_left    = 0;
    int   stall_left  = 0;
    int   cycle_count = 0;
    int   error_count = 0;
    int   samples_in  = 0;
    int   averages_ok = 0;
    int   window_writes = 0;
    int   items_queued  = 0;

    sliding_window_average_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wen  (cfg_wen),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Advance the ring, update the running sum and return the average
    function automatic logic [15:0] advance_window_average(input logic [15:0] smp);
        int n;
        int total;
        int avg;
        n = int'(window_len_cfg);
        if (n == 0) n = 1;
        if (n > WINDOW_MAX_DEF) n = WINDOW_MAX_DEF;
        window_ptr = 8'((int'(window_ptr) + 1) % n);
        total = int'($signed(window_sum)) - int'(window_samples[window_ptr])
              + int'($signed(smp));
        window_samples[window_ptr] = smp;
        window_sum = total[23:0];
        avg = int'($signed(window_sum)) / n;
        if (avg > 32767) avg = 32767;
        if (avg < -32768) avg = -32768;
        return avg[15:0];
    endfunction

    function automatic logic [15:0] pick_sample(input sample_src_t src);
        logic [15:0] v;
        v = 16'($urandom);
        case (src)
            SRC_POS_RAIL: begin
                if ($urandom_range(0, 7) != 0) v = 16'h7FFF;
            end
            SRC_NEG_RAIL: begin
                if ($urandom_range(0, 7) != 0) v = 16'h8000;
            end
            SRC_NEAR_ZERO: begin
                v = 16'($signed($urandom_range(0, 64)) - 32);
            end
            default: begin
            end
        endcase
        return v;
    endfunction

    // Sample stream driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_fire) begin
            if (idle_on && gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                gap_left <= $urandom_range(0, 18);
                s_tvalid <= 1'b0;
            end else if (sample_backlog.size() != 0) begin
                s_tdata  <= sample_backlog.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Average stream receiver
    always @(negedge aclk) begin
        if (idle_on && stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 18);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= aresetn;
        end
    end

    // Monitor: predict on sample transfer, check on average transfer
    always @(posedge aclk) begin
        logic [15:0] want;
        s_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            average_backlog.push_back(advance_window_average(s_tdata));
            samples_in++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (average_backlog.size() == 0) begin
                $display("%0t: unexpected average %0d, none pending",
                         $time, $signed(m_tdata));
                error_count++;
            end else begin
                want = average_backlog.pop_front();
                if (want !== m_tdata) begin
                    $display("%0t: average mismatch: expected %0d, actual %0d",
                             $time, $signed(want), $signed(m_tdata));
                    error_count++;
                end else begin
                    averages_ok++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d averages pending",
                     $time, average_backlog.size());
            $display("sliding_window_average_top test failed");
            $finish;
        end
    end

    task automatic set_window(input logic [LEN_W-1:0] len);
        @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= len;
        window_len_cfg = len;
        window_writes++;
        @(negedge aclk);
        cfg_wen <= 1'b0;
    endtask

    task automatic drain_and_settle();
        do @(posedge aclk);
        while (sample_backlog.size() != 0 || s_tvalid || average_backlog.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic run_phase(input int n_items, input sample_src_t src, input bit idle_en);
        idle_on = idle_en;
        for (int i = 0; i < n_items; i++) begin
            sample_backlog.push_back(pick_sample(src));
        end
        items_queued += n_items;
        drain_and_settle();
    endtask

    initial begin
        logic [15:0] directed [20];
        logic [LEN_W-1:0] len;
        sample_src_t src;
        foreach (window_samples[i]) window_samples[i] = '0;
        directed = '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h0000, 16'hFFFF,
                     16'h0001, 16'h5555, 16'hAAAA, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                     16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h8001, 16'h7FFE,
                     16'h00FF, 16'hFF00};

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset window length, ring wraps past 16
        idle_on = 1'b1;
        foreach (directed[i]) sample_backlog.push_back(directed[i]);
        items_queued += 20;
        drain_and_settle();

        set_window(9'd1);
        run_phase(30, SRC_FULL, 1'b1);
        // Fill the full window near the positive rail, then shrink it
        set_window(9'd256);
        run_phase(300, SRC_POS_RAIL, 1'b0);
        set_window(9'd1);
        run_phase(12, SRC_FULL, 1'b1);
        set_window(9'd0);
        run_phase(12, SRC_NEAR_ZERO, 1'b1);
        set_window(9'd511);
        run_phase(300, SRC_NEG_RAIL, 1'b1);
        set_window(9'd3);
        run_phase(15, SRC_FULL, 1'b0);
        set_window(9'd257);
        run_phase(60, SRC_FULL, 1'b1);

        while (items_queued < ITEM_TARGET - 60) begin
            case ($urandom_range(0, 5))
                0:       len = 9'd0;
                1:       len = 9'd1;
                2:       len = 9'd256;
                3:       len = 9'($urandom_range(257, 511));
                default: len = 9'($urandom_range(2, 255));
            endcase
            case ($urandom_range(0, 5))
                0:       src = SRC_POS_RAIL;
                1:       src = SRC_NEG_RAIL;
                2:       src = SRC_NEAR_ZERO;
                default: src = SRC_FULL;
            endcase
            set_window(len);
            run_phase($urandom_range(15, 70), src, $urandom_range(0, 3) != 0);
        end

        // Closing stretch at full rate
        set_window(9'($urandom_range(2, 255)));
        run_phase(60, SRC_FULL, 1'b0);

        if (average_backlog.size() != 0) begin
            $display("%0t: %0d averages never arrived", $time, average_backlog.size());
            error_count++;
        end
        $display("Streamed %0d samples through %0d window settings,", samples_in,
                 window_writes + 1);
        $display("%0d averages matched, %0d mismatches.", averages_ok, error_count);
        if (error_count == 0) begin
            $display("sliding_window_average_top test passed");
        end else begin
            $display("sliding_window_average_top test failed");
        end
        $finish;
    end

endmodule
